[hdl/lzfd_pkg.sv]
// Shared types and constants of the LZ4 frame decompressor.
// No dependencies; every other file imports this package.
package lzfd_pkg;

	localparam int unsigned HIST_AW = 16;

	localparam logic [31:0] SIG_MODERN = 32'h184D2204;
	localparam logic [31:0] SIG_LEGACY = 32'h184C2102;
	localparam logic [30:0] SIZE_MAX = 31'h7FFFFFFF;
	localparam logic [16:0] HIST_FULL = 17'd65536;
	localparam logic [3:0] LOW_NIBBLE = 4'hF;
	localparam logic [7:0] LEN_EXT = 8'd255;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_SIG = 3'd1;
	localparam logic [2:0] ERR_VER = 3'd2;
	localparam logic [2:0] ERR_ZERO_OFF = 3'd3;
	localparam logic [2:0] ERR_FAR_OFF = 3'd4;
	localparam logic [2:0] ERR_BYTE_COPY = 3'd5;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [13:0] {
		PH_SIG = 14'b00000000000001,
		PH_FLG = 14'b00000000000010,
		PH_HDRSKIP = 14'b00000000000100,
		PH_BSIZE = 14'b00000000001000,
		PH_RAW = 14'b00000000010000,
		PH_TOKEN = 14'b00000000100000,
		PH_LITLEN = 14'b00000001000000,
		PH_LIT = 14'b00000010000000,
		PH_OFF0 = 14'b00000100000000,
		PH_OFF1 = 14'b00001000000000,
		PH_MLEN = 14'b00010000000000,
		PH_COPY = 14'b00100000000000,
		PH_BCSUM = 14'b01000000000000,
		PH_CCSUM = 14'b10000000000000
	} phase_t;

	typedef struct packed {
		logic func;
		logic [7:0] in_byte;
	} in_t;

	typedef struct packed {
		logic out_valid;
		logic [7:0] out_byte;
		logic copy_pending;
		logic frame_end;
		logic [2:0] error_code;
	} out_t;

	// write/read request toward the history ring for one item
	typedef struct packed {
		logic emit;
		logic tick;
		logic [7:0] lit;
		logic [HIST_AW-1:0] wr_addr;
		logic [HIST_AW-1:0] rd_addr;
	} hist_req_t;

	// per-item status that travels with the result
	typedef struct packed {
		logic copy_pending;
		logic frame_end;
		logic [2:0] error_code;
	} step_stat_t;

endpackage

[hdl/lzfd_history.sv]
// 64 KiB history ring with registered synchronous read, delayed write-back
// and forwarding of the in-flight byte. Depends on lzfd_pkg.
module lzfd_history import lzfd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic acc,
	input hist_req_t req,
	output logic [7:0] byte_o
);

	logic [7:0] mem [0:(1<<HIST_AW)-1];
	hist_req_t req_s2;
	logic [7:0] rd_s2;
	logic fwd_s2;
	logic [7:0] fwd_dat_s2;
	logic wr_pend_q;

	assign byte_o = !req_s2.tick ? req_s2.lit : (fwd_s2 ? fwd_dat_s2 : rd_s2);

	always_ff @(posedge clk) begin
		if (wr_pend_q) begin
			mem[req_s2.wr_addr] <= byte_o;
		end
		if (acc) begin
			rd_s2 <= mem[req.rd_addr];
			req_s2 <= req;
			fwd_s2 <= wr_pend_q && (req_s2.wr_addr == req.rd_addr);
			fwd_dat_s2 <= byte_o;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
		end else if (acc) begin
			wr_pend_q <= req.emit;
		end else begin
			wr_pend_q <= 1'b0;
		end
	end

	a_wr_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_q && !acc |=> !wr_pend_q)
		else $error("ring write-back repeated");
	a_pend_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_q |-> $past(acc))
		else $error("write-back without a transfer");
	a_fwd_tick: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.tick && wr_pend_q && req_s2.wr_addr == req.rd_addr |=> fwd_s2)
		else $error("missed forward");

endmodule

[hdl/lzfd_parser.sv]
// Frame and block parser: header, block sizes, tokens, lengths, offsets,
// copy bookkeeping and ring pointers. Depends on lzfd_pkg.
module lzfd_parser import lzfd_pkg::*; #(
	parameter int unsigned LEGACY_BLOCK_OUTPUT = 8388608
) (
	input logic clk,
	input logic arst_n,
	input logic acc,
	input in_t item,
	output hist_req_t req,
	output step_stat_t stat
);

	phase_t phase_q;
	logic [31:0] shift_q, run_q, mrem_q;
	logic [3:0] cnt_q, tlow_q;
	logic [30:0] blk_q;
	logic [15:0] moff_q, wp_q;
	logic [2:0] flags_q, err_q; // flags: 0 block csum, 1 content csum, 2 legacy
	logic [23:0] total_q;
	logic [16:0] hist_q;

	phase_t phase_n;
	logic [31:0] shift_n, run_n, mrem_n;
	logic [3:0] cnt_n, tlow_n;
	logic [30:0] blk_n;
	logic [15:0] moff_n, wp_n;
	logic [2:0] flags_n, err_n;
	logic [23:0] total_n;
	logic [16:0] hist_n;
	logic emit, bdone, fin, fend;

	always_comb begin
		logic [7:0] b;
		logic [31:0] v;
		logic [30:0] size;
		logic cmp;
		logic [32:0] sum;
		b = item.in_byte;
		v = '0;
		size = '0;
		cmp = 1'b0;
		sum = '0;
		phase_n = phase_q; shift_n = shift_q; run_n = run_q; mrem_n = mrem_q;
		cnt_n = cnt_q; tlow_n = tlow_q; blk_n = blk_q; moff_n = moff_q;
		wp_n = wp_q; flags_n = flags_q; err_n = err_q; total_n = total_q;
		hist_n = hist_q;
		emit = 1'b0; bdone = 1'b0; fin = 1'b0; fend = 1'b0;
		req.tick = 1'b0;
		req.lit = b;
		req.wr_addr = wp_q;
		req.rd_addr = wp_q - moff_q;
		if (err_q == ERR_NONE) begin
			if (item.func == FUNC_TICK) begin
				if (phase_q == PH_COPY) begin
					emit = 1'b1;
					req.tick = 1'b1;
					if (mrem_n != '0) mrem_n = mrem_n - 32'd1;
					if (mrem_n == '0) begin
						if (blk_n == '0) bdone = 1'b1;
						else phase_n = PH_TOKEN;
					end
				end
			end else begin
				// consume one block byte where the block is being walked
				if (phase_q == PH_RAW || phase_q == PH_TOKEN || phase_q == PH_LITLEN ||
				    phase_q == PH_LIT || phase_q == PH_OFF0 || phase_q == PH_OFF1 ||
				    phase_q == PH_MLEN) begin
					if (blk_n != '0) blk_n = blk_n - 31'd1;
				end
				unique case (phase_q)
					PH_SIG, PH_BSIZE: begin
						v = shift_q | (32'(b) << {cnt_q[1:0], 3'b000});
						shift_n = v;
						cnt_n = cnt_q + 4'd1;
						if (cnt_n >= 4'd4) begin
							if (phase_q == PH_SIG) begin
								hist_n = '0;
								total_n = '0;
								if (v == SIG_MODERN) begin
									flags_n = '0;
									phase_n = PH_FLG; shift_n = '0; cnt_n = '0;
								end else if (v == SIG_LEGACY) begin
									flags_n = 3'b100;
									phase_n = PH_BSIZE; shift_n = '0; cnt_n = '0;
								end else begin
									err_n = ERR_SIG;
								end
							end else begin
								if (flags_q[2]) begin
									size = v[31] ? SIZE_MAX : v[30:0];
									cmp = 1'b1;
								end else begin
									size = v[30:0];
									cmp = !v[31];
								end
								if (size == '0) begin
									if (flags_q[1]) begin
										phase_n = PH_CCSUM; cnt_n = 4'd4;
									end else begin
										fin = 1'b1;
									end
								end else begin
									blk_n = size;
									phase_n = cmp ? PH_TOKEN : PH_RAW;
								end
							end
						end
					end
					PH_FLG: begin
						if (b[7:6] != 2'b01) begin
							err_n = ERR_VER;
						end else begin
							flags_n = {1'b0, b[2], b[4]};
							cnt_n = 4'd2 + (b[3] ? 4'd8 : 4'd0) + (b[0] ? 4'd4 : 4'd0);
							phase_n = PH_HDRSKIP;
						end
					end
					PH_HDRSKIP, PH_BCSUM, PH_CCSUM: begin
						if (cnt_n != '0) cnt_n = cnt_n - 4'd1;
						if (cnt_n == '0) begin
							if (phase_q == PH_CCSUM) begin
								fin = 1'b1;
							end else begin
								phase_n = PH_BSIZE; shift_n = '0; cnt_n = '0;
							end
						end
					end
					PH_RAW: begin
						emit = 1'b1;
						if (blk_n == '0) bdone = 1'b1;
					end
					PH_TOKEN: begin
						tlow_n = b[3:0] & LOW_NIBBLE;
						run_n = 32'(b[7:4]);
						if (b[7:4] == LOW_NIBBLE) phase_n = PH_LITLEN;
						else if (b[7:4] == '0) begin
							if (blk_n == '0) bdone = 1'b1;
							else phase_n = PH_OFF0;
						end else phase_n = PH_LIT;
					end
					PH_LITLEN: begin
						sum = {1'b0, run_q} + 33'(b);
						run_n = sum[32] ? '1 : sum[31:0];
						if (b != LEN_EXT) phase_n = PH_LIT;
					end
					PH_LIT: begin
						emit = 1'b1;
						if (run_n != '0) run_n = run_n - 32'd1;
						if (run_n == '0) begin
							if (blk_n == '0) bdone = 1'b1;
							else phase_n = PH_OFF0;
						end
					end
					PH_OFF0: begin
						moff_n = 16'(b);
						phase_n = PH_OFF1;
					end
					PH_OFF1: begin
						moff_n = {b, moff_q[7:0]};
						if (moff_n == '0) err_n = ERR_ZERO_OFF;
						else if (17'(moff_n) > hist_q) err_n = ERR_FAR_OFF;
						else begin
							mrem_n = 32'd4 + 32'(tlow_q);
							phase_n = (tlow_q == LOW_NIBBLE) ? PH_MLEN : PH_COPY;
						end
					end
					PH_MLEN: begin
						sum = {1'b0, mrem_q} + 33'(b);
						mrem_n = sum[32] ? '1 : sum[31:0];
						if (b != LEN_EXT) phase_n = PH_COPY;
					end
					PH_COPY: err_n = ERR_BYTE_COPY;
					default: begin
						phase_n = PH_SIG; shift_n = '0; cnt_n = '0;
					end
				endcase
			end
			if (emit) begin
				wp_n = wp_q + 16'd1;
				if (hist_q < HIST_FULL) hist_n = hist_q + 17'd1;
				if (total_q != '1) total_n = total_q + 24'd1;
			end
			if (bdone) begin
				if (flags_q[2]) begin
					if ({1'b0, total_n} < 25'(LEGACY_BLOCK_OUTPUT)) fin = 1'b1;
					else begin
						phase_n = PH_BSIZE; shift_n = '0; cnt_n = '0;
					end
				end else if (flags_q[0]) begin
					phase_n = PH_BCSUM; cnt_n = 4'd4;
				end else begin
					phase_n = PH_BSIZE; shift_n = '0; cnt_n = '0;
				end
			end
			if (fin) begin
				phase_n = PH_SIG; shift_n = '0; cnt_n = '0;
				flags_n = '0;
				fend = 1'b1;
			end
		end
		if (err_n != ERR_NONE) begin
			emit = 1'b0;
			fend = 1'b0;
		end
		req.emit = emit;
		stat.copy_pending = (err_n == ERR_NONE) && (phase_n == PH_COPY);
		stat.frame_end = fend;
		stat.error_code = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG; shift_q <= '0; run_q <= '0; mrem_q <= '0;
			cnt_q <= '0; tlow_q <= '0; blk_q <= '0; moff_q <= '0; wp_q <= '0;
			flags_q <= '0; err_q <= ERR_NONE; total_q <= '0; hist_q <= '0;
		end else if (acc) begin
			phase_q <= phase_n; shift_q <= shift_n; run_q <= run_n; mrem_q <= mrem_n;
			cnt_q <= cnt_n; tlow_q <= tlow_n; blk_q <= blk_n; moff_q <= moff_n;
			wp_q <= wp_n; flags_q <= flags_n; err_q <= err_n; total_q <= total_n;
			hist_q <= hist_n;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ERR_NONE |=> err_q == $past(err_q))
		else $error("error code changed after being set");
	a_wp_emit: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !req.emit |=> wp_q == $past(wp_q))
		else $error("write pointer moved without a byte");
	a_hist_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hist_q <= HIST_FULL)
		else $error("history count above ring depth");

endmodule

[hdl/lz4_frame_decompressor_unit.sv]
// LZ4 frame decompressor top level: parser, history ring and result register.
// Depends on lzfd_pkg, lzfd_parser and lzfd_history.
// Result is valid in the cycle after the input transfer; one item per cycle
// while out_ready is high, ticks included, set by the single ring read port.
// Reset (arst_n low, asynchronous) clears parser state and result valid flag;
// ring contents are not cleared, so no clearing pass is needed.
module lz4_frame_decompressor_unit import lzfd_pkg::*; #(
	parameter int unsigned LEGACY_BLOCK_OUTPUT = 8388608
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data
);

	logic acc;
	hist_req_t req;
	step_stat_t stat;
	logic [7:0] ring_byte;

	// result stage: holds the status of the item whose byte the ring resolves
	logic out_v_q;
	logic emit_s2;
	step_stat_t stat_s2;

	// advance whenever the result slot is empty or being drained this cycle
	assign in_ready = !out_v_q || out_ready;
	assign acc = in_valid && in_ready;

	lzfd_parser #(
		.LEGACY_BLOCK_OUTPUT(LEGACY_BLOCK_OUTPUT)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.item(in_data),
		.req(req),
		.stat(stat)
	);

	// ring read issues on the transfer edge; data lands with the result stage
	lzfd_history u_history (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.req(req),
		.byte_o(ring_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (acc) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			emit_s2 <= req.emit;
			stat_s2 <= stat;
		end
	end

	assign out_valid = out_v_q;
	assign out_data.out_valid = emit_s2;
	assign out_data.out_byte = emit_s2 ? ring_byte : 8'd0;
	assign out_data.copy_pending = stat_s2.copy_pending;
	assign out_data.frame_end = stat_s2.frame_end;
	assign out_data.error_code = stat_s2.error_code;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_v_q)
		else $error("transfer did not fill the result stage");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready |=> out_v_q && !$past(acc))
		else $error("result overwritten while stalled");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && stat_s2.error_code != ERR_NONE |-> !emit_s2 && !stat_s2.copy_pending)
		else $error("output during error");

endmodule
